@@ rtl/frpv_pkg.sv @@
// ----------------------------------------------------------------------------
// frpv_pkg: shared types and constants
// Shared types and constants for the frame rate pacer with vsync tracking.
// ----------------------------------------------------------------------------
package frpv_pkg;

  localparam logic [23:0] Rate60 = 24'd3932160;
  localparam logic [23:0] RateMin = 24'd3276800;
  localparam logic [23:0] RateMax = 24'd7864320;
  localparam logic [35:0] RateNum = 36'd65536000000;
  localparam logic [8:0] CheckPeriod = 9'd300;
  // Moving average weights in Q0.16: the kept share and the new share.
  localparam logic [16:0] EmaKeep = 17'd64881;
  localparam logic [16:0] EmaAlpha = 17'd655;

  typedef enum logic [1:0] {
    OP_STEP  = 2'd0,
    OP_VSYNC = 2'd1,
    OP_RESET = 2'd2,
    OP_INIT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_GAME = 2'd0,
    REG_NOM  = 2'd1,
    REG_TOL  = 2'd2,
    REG_WARM = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL_OLD,
    ST_MUL_NEW,
    ST_CHECK,
    ST_TOL_START,
    ST_TOL
  } state_e;

endpackage

@@ rtl/frpv_div.sv @@
// ----------------------------------------------------------------------------
// frpv_div: bit-serial rate divider
// Restoring division of the fixed rate numerator by the vsync interval,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module frpv_div #(
  parameter int unsigned TimeWidth = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [TimeWidth-1:0] divisor_i,
  output logic                 busy_o,
  output logic [35:0]          quot_o
);

  localparam int unsigned CmpW = (TimeWidth > 37) ? TimeWidth : 37;

  logic [35:0]          num_q;
  logic [35:0]          rem_q;
  logic [TimeWidth-1:0] dvs_q;
  logic [5:0]           cnt_q;
  logic                 busy_q;
  logic [36:0]          trial;
  logic [35:0]          diff;
  logic                 fits;

  always_comb begin
    trial = {rem_q, num_q[35]};
    // A divisor wider than the partial remainder simply never fits.
    fits  = CmpW'(trial) >= CmpW'(dvs_q);
    diff  = 36'(trial - 37'(dvs_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 6'd35;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= frpv_pkg::RateNum;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff : trial[35:0];
      num_q <= {num_q[34:0], fits};
    end
  end

  assign quot_o = num_q;
  assign busy_o = busy_q;

endmodule

@@ rtl/frpv_mac.sv @@
// ----------------------------------------------------------------------------
// frpv_mac: serial multiply unit
// Shift-and-add multiplier: a 24-bit multiplicand times a 17-bit multiplier,
// one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module frpv_mac (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [23:0] a_i,
  input  logic [16:0] b_i,
  output logic        busy_o,
  output logic [40:0] prod_o
);

  logic [40:0] acc_q;
  logic [40:0] a_q;
  logic [16:0] b_q;
  logic [4:0]  cnt_q;
  logic        busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 5'd16;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 5'd1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= {17'd0, a_i};
      b_q   <= b_i;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[39:0], 1'b0};
      b_q <= {1'b0, b_q[16:1]};
    end
  end

  assign busy_o = busy_q;
  assign prod_o = acc_q;

endmodule

@@ rtl/frame_rate_pacer_with_vsync_tracking_core.sv @@
// ----------------------------------------------------------------------------
// frame_rate_pacer_with_vsync_tracking_core: frame rate pacer top level
// Bresenham frame pacer with vsync rate measurement, moving average and
// drift correction.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents, lowest bits first
// s_axis    in   tdata = op[1:0], timestamp_us[65:2]
// m_axis    out  tdata = step_frame, pass_through, stable, measured, display, drift
// apb       in   four configuration registers at byte addresses 0,4,8,12
//
// Step and accumulator reset transactions, and a vsync that forms no interval,
// show their result the cycle after acceptance; init waits for the serial
// tolerance product. Other vsyncs run the serial divider (a rejected rate ends
// there), two serial multiplies for the moving average once it holds a sample,
// and the tolerance product when a drift reloads the display rate. One
// transaction is in flight at a time; the next input is taken the cycle after
// the result leaves. Reset restores the power-up rates; there is no clearing pass.
module frame_rate_pacer_with_vsync_tracking_core #(
  parameter int unsigned TIME_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // op[1:0], timestamp_us[65:2], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // step_frame[0], pass_through[1], stable[2], measured_rate_q16[26:3],
  // display_rate_q16[50:27], drift_applied[51], zero pad
  output logic [55:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [23:0] game_reg_q, nom_reg_q;
  logic [15:0] tol_reg_q, warm_reg_q;
  logic [23:0] game_q, disp_q, avg_q, rate_q;
  logic [31:0] acc_q, cnt_q;
  logic [8:0]  per_q;
  logic [TIME_WIDTH-1:0] prev_q;
  logic        have_q, dir_q;
  logic        frame_q, drift_q;
  logic        out_v_q;
  logic [40:0] part_q;

  frpv_pkg::state_e state_q, state_d;
  frpv_pkg::op_e op;
  logic        dstart, dbusy, mstart, mbusy;
  logic [35:0] quot;
  logic [23:0] ma;
  logic [16:0] mb;
  logic [40:0] prod;
  logic        accept;
  logic [TIME_WIDTH-1:0] ts, interval;
  logic        skip_vsync;
  logic        in_band;
  logic [23:0] diffm, tdiff, init_rate;
  logic        tol_ok;
  logic [8:0]  per_n;
  logic [31:0] cnt_n;
  logic        check, drift_hit;
  logic        stable;
  logic [40:0] ema_sum;

  assign pready = 1'b1;
  assign op     = frpv_pkg::op_e'(s_axis_tdata[1:0]);
  assign ts     = s_axis_tdata[TIME_WIDTH+1:2];
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == frpv_pkg::ST_IDLE) && !out_v_q;
  assign interval = ts - prev_q;
  // The first vsync, a zero interval and a saturated count form no sample.
  assign skip_vsync = !have_q || interval == '0 || cnt_q == '1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      game_reg_q <= frpv_pkg::Rate60;
      nom_reg_q  <= frpv_pkg::Rate60;
      tol_reg_q  <= 16'd328;
      warm_reg_q <= 16'd120;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        frpv_pkg::REG_GAME: game_reg_q <= pwdata[23:0];
        frpv_pkg::REG_NOM:  nom_reg_q  <= pwdata[23:0];
        frpv_pkg::REG_TOL:  tol_reg_q  <= pwdata[15:0];
        frpv_pkg::REG_WARM: warm_reg_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      frpv_pkg::REG_GAME: prdata = {8'd0, game_reg_q};
      frpv_pkg::REG_NOM:  prdata = {8'd0, nom_reg_q};
      frpv_pkg::REG_TOL:  prdata = {16'd0, tol_reg_q};
      frpv_pkg::REG_WARM: prdata = {16'd0, warm_reg_q};
      default:            prdata = '0;
    endcase
  end

  frpv_div #(.TimeWidth(TIME_WIDTH)) u_div (
    .clk_i, .rst_ni, .start_i(dstart), .divisor_i(interval),
    .busy_o(dbusy), .quot_o(quot)
  );

  frpv_mac u_mac (
    .clk_i, .rst_ni, .start_i(mstart), .a_i(ma), .b_i(mb),
    .busy_o(mbusy), .prod_o(prod)
  );

  assign in_band   = quot[35:24] == '0 && quot[23:0] >= frpv_pkg::RateMin
                     && quot[23:0] <= frpv_pkg::RateMax;
  assign ema_sum   = part_q + prod + 41'd32768;
  assign diffm     = (avg_q > disp_q) ? avg_q - disp_q : disp_q - avg_q;
  assign tdiff     = (game_q > disp_q) ? game_q - disp_q : disp_q - game_q;
  assign tol_ok    = {1'b0, tdiff, 16'd0} < prod;
  assign init_rate = (nom_reg_q == '0) ? frpv_pkg::Rate60 : nom_reg_q;
  assign cnt_n     = cnt_q + 32'd1;
  assign per_n     = (per_q + 9'd1 >= frpv_pkg::CheckPeriod) ? 9'd0 : per_q + 9'd1;
  assign check     = cnt_q >= {16'd0, warm_reg_q}
                     && (cnt_q == {16'd0, warm_reg_q} || per_q == '0);
  assign drift_hit = check && ({10'd0, diffm} * 34'd1000) > {10'd0, disp_q};
  assign stable    = cnt_q >= {16'd0, warm_reg_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      frpv_pkg::ST_IDLE: begin
        if (accept && op == frpv_pkg::OP_INIT) begin
          state_d = frpv_pkg::ST_TOL_START;
        end else if (accept && op == frpv_pkg::OP_VSYNC && !skip_vsync) begin
          state_d = frpv_pkg::ST_DIV;
        end
      end
      frpv_pkg::ST_DIV: begin
        if (!dbusy) begin
          if (!in_band) begin
            state_d = frpv_pkg::ST_IDLE;
          end else if (avg_q == '0) begin
            state_d = frpv_pkg::ST_CHECK;
          end else begin
            state_d = frpv_pkg::ST_MUL_OLD;
          end
        end
      end
      frpv_pkg::ST_MUL_OLD: if (!mbusy) begin
        state_d = frpv_pkg::ST_MUL_NEW;
      end
      frpv_pkg::ST_MUL_NEW: if (!mbusy) begin
        state_d = frpv_pkg::ST_CHECK;
      end
      frpv_pkg::ST_CHECK: begin
        state_d = drift_hit ? frpv_pkg::ST_TOL_START : frpv_pkg::ST_IDLE;
      end
      frpv_pkg::ST_TOL_START: state_d = frpv_pkg::ST_TOL;
      frpv_pkg::ST_TOL: if (!mbusy) begin
        state_d = frpv_pkg::ST_IDLE;
      end
      default: state_d = frpv_pkg::ST_IDLE;
    endcase
  end

  // The multiplier serves the moving average (two passes) and the
  // tolerance product against the display rate just loaded (one pass).
  always_comb begin
    dstart = accept && op == frpv_pkg::OP_VSYNC && !skip_vsync;
    mstart = 1'b0;
    ma     = avg_q;
    mb     = frpv_pkg::EmaKeep;
    case (state_q)
      frpv_pkg::ST_DIV: mstart = !dbusy && in_band && avg_q != '0;
      frpv_pkg::ST_MUL_OLD: begin
        mstart = !mbusy;
        ma     = rate_q;
        mb     = frpv_pkg::EmaAlpha;
      end
      frpv_pkg::ST_TOL_START: begin
        mstart = 1'b1;
        ma     = disp_q;
        mb     = {1'b0, tol_reg_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frpv_pkg::ST_IDLE;
      out_v_q <= 1'b0;
      frame_q <= 1'b0;
      drift_q <= 1'b0;
      acc_q   <= {8'd0, frpv_pkg::Rate60};
      disp_q  <= frpv_pkg::Rate60;
      game_q  <= frpv_pkg::Rate60;
      dir_q   <= 1'b0;
      avg_q   <= '0;
      rate_q  <= '0;
      part_q  <= '0;
      cnt_q   <= '0;
      per_q   <= '0;
      prev_q  <= '0;
      have_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (m_axis_tvalid && m_axis_tready) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        frpv_pkg::ST_IDLE: if (accept) begin
          frame_q <= 1'b0;
          drift_q <= 1'b0;
          case (op)
            frpv_pkg::OP_STEP: begin
              if (dir_q) begin
                frame_q <= 1'b1;
              end else if (acc_q >= {8'd0, disp_q}) begin
                acc_q   <= acc_q - {8'd0, disp_q} + {8'd0, game_q};
                frame_q <= 1'b1;
              end else begin
                acc_q <= acc_q + {8'd0, game_q};
              end
              out_v_q <= 1'b1;
            end
            frpv_pkg::OP_VSYNC: begin
              prev_q <= ts;
              have_q <= 1'b1;
              if (skip_vsync) begin
                out_v_q <= 1'b1;
              end
            end
            frpv_pkg::OP_RESET: begin
              acc_q   <= {8'd0, disp_q};
              out_v_q <= 1'b1;
            end
            frpv_pkg::OP_INIT: begin
              game_q <= game_reg_q;
              disp_q <= init_rate;
              acc_q  <= {8'd0, init_rate};
              avg_q  <= '0;
              prev_q <= '0;
              have_q <= 1'b0;
              cnt_q  <= '0;
              per_q  <= '0;
            end
            default: ;
          endcase
        end
        frpv_pkg::ST_DIV: if (!dbusy) begin
          rate_q <= quot[23:0];
          if (!in_band) begin
            out_v_q <= 1'b1;
          end else begin
            cnt_q <= cnt_n;
            per_q <= per_n;
            if (avg_q == '0) begin
              avg_q <= quot[23:0];
            end
          end
        end
        frpv_pkg::ST_MUL_OLD: if (!mbusy) begin
          part_q <= prod;
        end
        frpv_pkg::ST_MUL_NEW: if (!mbusy) begin
          avg_q <= ema_sum[39:16];
        end
        frpv_pkg::ST_CHECK: begin
          if (drift_hit) begin
            disp_q  <= avg_q;
            acc_q   <= {8'd0, avg_q};
            drift_q <= 1'b1;
          end else begin
            out_v_q <= 1'b1;
          end
        end
        frpv_pkg::ST_TOL: if (!mbusy) begin
          dir_q   <= tol_ok;
          out_v_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {4'd0, drift_q, disp_q, stable ? avg_q : 24'd0, stable, dir_q,
                          frame_q};

  a_one_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid) else $error("input taken with result pending");
  a_idle_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> state_q == frpv_pkg::ST_IDLE) else $error("result shown mid sequence");
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");
  a_drift_vsync : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[51]) |-> m_axis_tdata[50:27] != '0)
    else $error("drift reload to zero rate");

endmodule

@@ tb/frame_rate_pacer_with_vsync_tracking_core_test.sv @@
// ----------------------------------------------------------------------------
// Frame rate pacer core testbench
// Drives step, vsync, accumulator reset and init transactions through the
// input stream with random gaps, predicts each result with an independent
// model of the pacer, and compares every output transaction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module frame_rate_pacer_with_vsync_tracking_core_test;

  typedef struct packed {
    logic        drift;
    logic [23:0] display;
    logic [23:0] measured;
    logic        stable;
    logic        direct;
    logic        frame;
  } pace_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  frame_rate_pacer_with_vsync_tracking_core uut (.*);

  // Register shadows and pacer state.
  logic [23:0] cfg_game = frpv_pkg::Rate60, cfg_nominal = frpv_pkg::Rate60;
  logic [15:0] cfg_tol = 16'd328, cfg_warmup = 16'd120;
  logic [31:0] pace_acc = 32'(frpv_pkg::Rate60);
  logic [23:0] pace_disp = frpv_pkg::Rate60, pace_game = frpv_pkg::Rate60, avg_rate = '0;
  logic        pace_direct = 1'b0, have_prev = 1'b0;
  logic [31:0] sample_cnt = '0;
  logic [8:0]  period_cnt = '0;
  logic [63:0] prev_time = '0, vsync_time = '0;

  pace_result_t expected_results[$];
  int errors = 0;
  int unsigned cycles = 0;

  initial forever #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic near_rate(logic [23:0] g, logic [23:0] d);
    logic [63:0] diff;
    diff = (g > d) ? 64'(g - d) : 64'(d - g);
    return (diff << 16) < 64'(cfg_tol) * 64'(d);
  endfunction

  function automatic pace_result_t predict_pacer(frpv_pkg::op_e op, logic [63:0] ts);
    pace_result_t r;
    logic [63:0] interval, rate, sum, m, c, diff;
    logic stab;
    r = '0;
    case (op)
      frpv_pkg::OP_STEP: begin
        if (pace_direct) r.frame = 1'b1;
        else if (pace_acc >= 32'(pace_disp)) begin
          pace_acc = pace_acc - 32'(pace_disp) + 32'(pace_game);
          r.frame = 1'b1;
        end else pace_acc = pace_acc + 32'(pace_game);
      end
      frpv_pkg::OP_VSYNC: begin
        if (have_prev) begin
          interval = ts - prev_time;
          if (interval != 0) begin
            rate = 64'd65536000000 / interval;
            if (rate >= 64'(frpv_pkg::RateMin) && rate <= 64'(frpv_pkg::RateMax) &&
                sample_cnt != 32'hFFFFFFFF) begin
              sample_cnt = sample_cnt + 32'd1;
              period_cnt = (period_cnt + 9'd1 >= frpv_pkg::CheckPeriod) ? 9'd0
                           : period_cnt + 9'd1;
              if (avg_rate == 0) avg_rate = rate[23:0];
              else begin
                sum = 64'(avg_rate) * 64'd64881 + rate * 64'd655 + 64'd32768;
                avg_rate = sum[39:16];
              end
              if (sample_cnt >= 32'(cfg_warmup) &&
                  (sample_cnt == 32'(cfg_warmup) || period_cnt == 0)) begin
                m = 64'(avg_rate);
                c = 64'(pace_disp);
                diff = (m > c) ? m - c : c - m;
                if (diff * 64'd1000 > c) begin
                  pace_disp = avg_rate;
                  pace_acc = 32'(avg_rate);
                  pace_direct = near_rate(pace_game, avg_rate);
                  r.drift = 1'b1;
                end
              end
            end
          end
        end
        prev_time = ts;
        have_prev = 1'b1;
      end
      frpv_pkg::OP_RESET: pace_acc = 32'(pace_disp);
      default: begin
        pace_disp = (cfg_nominal != 0) ? cfg_nominal : frpv_pkg::Rate60;
        pace_game = cfg_game;
        pace_acc = 32'(pace_disp);
        prev_time = '0;
        have_prev = 1'b0;
        avg_rate = '0;
        sample_cnt = '0;
        period_cnt = '0;
        pace_direct = near_rate(pace_game, pace_disp);
      end
    endcase
    stab = sample_cnt >= 32'(cfg_warmup);
    r.direct = pace_direct;
    r.stable = stab;
    r.measured = stab ? avg_rate : '0;
    r.display = pace_disp;
    return r;
  endfunction

  // Output side: a random stall before each result, then field-by-field comparison.
  initial begin
    pace_result_t got, want;
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 4);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got = m_axis_tdata[51:0];
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.frame !== want.frame || got.direct !== want.direct ||
            got.stable !== want.stable || got.measured !== want.measured ||
            got.display !== want.display || got.drift !== want.drift) begin
          $display("%0t mismatch: expected %h, actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  // The valid stays up after acceptance only when the next item follows at once.
  task automatic send_op(frpv_pkg::op_e op, logic [63:0] ts = '0);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata <= {6'd0, ts, op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(predict_pacer(op, ts));
  endtask

  task automatic write_reg(frpv_pkg::reg_e idx, logic [31:0] val);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      frpv_pkg::REG_GAME: cfg_game = val[23:0];
      frpv_pkg::REG_NOM:  cfg_nominal = val[23:0];
      frpv_pkg::REG_TOL:  cfg_tol = val[15:0];
      frpv_pkg::REG_WARM: cfg_warmup = val[15:0];
      default: ;
    endcase
  endtask

  // Vsync with a period near the given microseconds, plus jitter.
  task automatic vsync_after(int unsigned period_us, int unsigned jitter);
    vsync_time = vsync_time + period_us + $urandom_range(0, jitter);
    send_op(frpv_pkg::OP_VSYNC, vsync_time);
  endtask

  task automatic test_directed();
    send_op(frpv_pkg::OP_STEP);
    send_op(frpv_pkg::OP_STEP);
    send_op(frpv_pkg::OP_INIT);
    send_op(frpv_pkg::OP_STEP);
    write_reg(frpv_pkg::REG_GAME, 32'd1966080);   // 30 Hz game on 60 Hz display
    write_reg(frpv_pkg::REG_NOM, 32'd0);
    write_reg(frpv_pkg::REG_TOL, 32'd0);
    write_reg(frpv_pkg::REG_WARM, 32'd1);
    send_op(frpv_pkg::OP_INIT);
    repeat (4) send_op(frpv_pkg::OP_STEP);
    send_op(frpv_pkg::OP_RESET);
    send_op(frpv_pkg::OP_VSYNC, 64'hFFFF_FFFF_FFFF_C000);
    send_op(frpv_pkg::OP_VSYNC, 64'hFFFF_FFFF_FFFF_C000);   // zero interval
    send_op(frpv_pkg::OP_VSYNC, 64'd2000);                  // wraps around zero
    send_op(frpv_pkg::OP_VSYNC, 64'd22000);                 // exactly 50 Hz
    send_op(frpv_pkg::OP_VSYNC, 64'd30333);                 // just above 120 Hz
    send_op(frpv_pkg::OP_VSYNC, 64'd30334);                 // far too fast
    send_op(frpv_pkg::OP_VSYNC, 64'd1030334);               // far too slow
    send_op(frpv_pkg::OP_STEP);
    send_op(frpv_pkg::OP_STEP);
  endtask

  task automatic test_extreme_regs();
    write_reg(frpv_pkg::REG_GAME, 32'hFFFFFF);
    write_reg(frpv_pkg::REG_NOM, 32'hFFFFFF);
    write_reg(frpv_pkg::REG_TOL, 32'hFFFF);
    write_reg(frpv_pkg::REG_WARM, 32'hFFFF);
    send_op(frpv_pkg::OP_INIT);
    repeat (3) send_op(frpv_pkg::OP_STEP);
    write_reg(frpv_pkg::REG_GAME, 32'd0);
    write_reg(frpv_pkg::REG_NOM, 32'd1);
    write_reg(frpv_pkg::REG_TOL, 32'd0);
    write_reg(frpv_pkg::REG_WARM, 32'd0);
    send_op(frpv_pkg::OP_INIT);
    repeat (3) send_op(frpv_pkg::OP_STEP);
  endtask

  // Mostly well-formed vsync trains so warmup and drift checks are reached.
  task automatic test_random(int unsigned count);
    int unsigned k, period;
    for (k = 0; k < count; k++) begin
      if (k % 150 == 0) begin
        write_reg(frpv_pkg::REG_GAME, $urandom_range(2500000, 7900000));
        write_reg(frpv_pkg::REG_NOM,
                  ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(3200000, 7900000));
        write_reg(frpv_pkg::REG_TOL, $urandom_range(0, 2000));
        write_reg(frpv_pkg::REG_WARM, $urandom_range(1, 40));
        send_op(frpv_pkg::OP_INIT);
        vsync_time = {$urandom, $urandom};
        period = $urandom_range(8400, 19900);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: vsync_after(period, 3);
        4, 5, 6: send_op(frpv_pkg::OP_STEP);
        7: send_op(frpv_pkg::OP_RESET);
        8: send_op(frpv_pkg::OP_VSYNC, {$urandom, $urandom});
        default: begin
          if ($urandom_range(0, 3) == 0) send_op(frpv_pkg::OP_INIT);
          else vsync_after($urandom_range(0, 30000), 0);
        end
      endcase
    end
  endtask

  // Long steady train so that the periodic drift check at 300 samples fires.
  task automatic test_period_check();
    int unsigned k;
    write_reg(frpv_pkg::REG_NOM, 32'd3932160);
    write_reg(frpv_pkg::REG_WARM, 32'd2);
    send_op(frpv_pkg::OP_INIT);
    for (k = 0; k < 330; k++) vsync_after((k < 150) ? 16667 : 16000, 0);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_extreme_regs();
    test_period_check();
    test_random(150);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/frpv_pkg.sv
rtl/frpv_div.sv
rtl/frpv_mac.sv
rtl/frame_rate_pacer_with_vsync_tracking_core.sv
tb/frame_rate_pacer_with_vsync_tracking_core_test.sv
